>>> src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the checker file lcs_checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, masked while reset is held.
`define LCS_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Clocked assertion that is also checked during reset.
`define LCS_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

>>> src/lcs_pkg.sv
// ----------------------------------------------------------------------------
// lcs_pkg
// Types and constants of the light contribution shader.
// ----------------------------------------------------------------------------
package lcs_pkg;

    // Register indexes of the configuration port
    localparam logic [2:0] CFG_MODE      = 3'd0;
    localparam logic [2:0] CFG_POSITION  = 3'd1;
    localparam logic [2:0] CFG_DIRECTION = 3'd2;
    localparam logic [2:0] CFG_COLOR     = 3'd3;
    localparam logic [2:0] CFG_INTENSITY = 3'd4;
    localparam logic [2:0] CFG_RADIUS    = 3'd5;
    localparam logic [2:0] CFG_CONE      = 3'd6;
    localparam logic [2:0] CFG_ACTIVE    = 3'd7;

    // Light types (mode bits 1:0); anything else acts as directional
    localparam logic [1:0] LT_POINT = 2'd1;
    localparam logic [1:0] LT_SPOT  = 2'd2;
    localparam int         MODE_INVSQ_BIT = 2;

    // Register reset values
    localparam logic [3:0]  RST_MODE      = 4'd5;
    localparam logic [59:0] RST_POSITION  = 60'd0;
    localparam logic [47:0] RST_DIRECTION = 48'd16384;
    localparam logic [47:0] RST_COLOR     = 48'hFFFF_FFFF_FFFF;
    localparam logic [15:0] RST_INTENSITY = 16'd256;
    localparam logic [19:0] RST_RADIUS    = 20'd16000;
    localparam logic [31:0] RST_CONE      = 32'd1085227008;
    localparam logic        RST_ACTIVE    = 1'b1;

    // Fixed-point constants
    localparam logic [16:0] ONE_Q16  = 17'd65536;
    localparam logic [14:0] L_MAX    = 15'd16384;
    localparam logic [28:0] OUT_MAX  = 29'd16777215;

    // Per-item context carried down the pipeline
    typedef struct packed {
        logic [2:0][15:0] nrm;       // normal, signed Q1.14
        logic [2:0][20:0] dlt;       // light minus point, signed
        logic [2:0][40:0] sq;        // squared deltas
        logic [39:0]      rr;        // radius squared
        logic [41:0]      s;         // squared distance
        logic             s_zero;
        logic             in_range;
        logic [61:0]      sq_x;      // sqrt remainder
        logic [62:0]      sq_r;      // sqrt root
        logic [42:0]      iv_d;      // inverse-square divisor
        logic [43:0]      iv_rem;
        logic [15:0]      iv_q;
        logic [2:0][31:0] ld_rem;    // light vector dividers
        logic [2:0][14:0] ld_q;
        logic [2:0]       ld_big;
        logic [30:0]      ra_rem;    // range ratio divider
        logic [29:0]      ra_d;
        logic [15:0]      ra_q;
        logic [2:0][16:0] lv;        // light vector, signed Q2.14
        logic [15:0]      fall;
        logic [2:0][32:0] cprod;
        logic [2:0][32:0] nprod;
        logic [16:0]      att;
        logic [34:0]      c;         // cone cosine, signed Q.28
        logic [31:0]      ndl;
        logic             cone_black;
        logic             cone_use;
        logic [31:0]      cn_rem;    // cone divider
        logic [31:0]      cn_d;
        logic [15:0]      cn_q;
        logic [15:0]      cone_sq;
        logic [2:0][31:0] ci;        // color times intensity
        logic [2:0][31:0] b;
        logic [2:0][63:0] v;
        logic [2:0][23:0] rgb;
    } t_stage;

endpackage

>>> src/light_contribution_shader_unit.sv
// ----------------------------------------------------------------------------
// light_contribution_shader_unit: diffuse RGB contribution of one light
// The pipeline depth is set by the 31-step sqrt and the two 16-step divider chains
// in series. Throughput one item per cycle while the output is not stalled.
// Synchronous active-low reset clears valid bits and loads register defaults.
// ----------------------------------------------------------------------------
module light_contribution_shader_unit
    import lcs_pkg::*;
#(
    parameter int COORD_FRAC_BITS = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration writes
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [59:0]        i_cfg_data,
    // input items
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [19:0] i_point_x,
    input  logic signed [19:0] i_point_y,
    input  logic signed [19:0] i_point_z,
    input  logic signed [15:0] i_normal_x,
    input  logic signed [15:0] i_normal_y,
    input  logic signed [15:0] i_normal_z,
    // result items
    output logic               o_valid,
    input  logic               i_ready,
    output logic [23:0]        o_red_out,
    output logic [23:0]        o_green_out,
    output logic [23:0]        o_blue_out
);

    // Stage map
    localparam int SQ_STEPS = 31;
    localparam int DV_STEPS = 16;
    localparam int LD_STEPS = 15;
    localparam int ST_SQR   = 1;
    localparam int ST_SUM   = 2;
    localparam int ST_SQ0   = 3;
    localparam int ST_IV0   = ST_SQ0 + 1;
    localparam int ST_DIV   = ST_SQ0 + SQ_STEPS;
    localparam int ST_DV0   = ST_DIV + 1;
    localparam int ST_LV    = ST_DV0 + DV_STEPS;
    localparam int ST_PROD  = ST_LV + 1;
    localparam int ST_DOT   = ST_PROD + 1;
    localparam int ST_CONE  = ST_DOT + 1;
    localparam int ST_CN0   = ST_CONE + 1;
    localparam int ST_CSQ   = ST_CN0 + DV_STEPS;
    localparam int ST_ATT   = ST_CSQ + 1;
    localparam int ST_MB    = ST_ATT + 1;
    localparam int ST_MV    = ST_MB + 1;
    localparam int LAST     = ST_MV + 1;

    localparam logic [43:0] IV_ONE = 44'(1) << (2 * COORD_FRAC_BITS);

    // Configuration registers
    logic [3:0]  r_mode;
    logic [59:0] r_pos;
    logic [47:0] r_dir;
    logic [47:0] r_color;
    logic [15:0] r_int;
    logic [19:0] r_rad;
    logic [31:0] r_cone;
    logic        r_act;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= RST_MODE;
            r_pos   <= RST_POSITION;
            r_dir   <= RST_DIRECTION;
            r_color <= RST_COLOR;
            r_int   <= RST_INTENSITY;
            r_rad   <= RST_RADIUS;
            r_cone  <= RST_CONE;
            r_act   <= RST_ACTIVE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MODE:      r_mode  <= i_cfg_data[3:0];
                CFG_POSITION:  r_pos   <= i_cfg_data;
                CFG_DIRECTION: r_dir   <= i_cfg_data[47:0];
                CFG_COLOR:     r_color <= i_cfg_data[47:0];
                CFG_INTENSITY: r_int   <= i_cfg_data[15:0];
                CFG_RADIUS:    r_rad   <= i_cfg_data[19:0];
                CFG_CONE:      r_cone  <= i_cfg_data[31:0];
                CFG_ACTIVE:    r_act   <= i_cfg_data[0];
            endcase
        end
    end

    logic w_pl;     // point or spot
    logic w_spot;
    logic w_invsq;
    assign w_pl    = (r_mode[1:0] == LT_POINT) || (r_mode[1:0] == LT_SPOT);
    assign w_spot  = (r_mode[1:0] == LT_SPOT);
    assign w_invsq = r_mode[MODE_INVSQ_BIT];

    // Pipeline registers and global advance
    t_stage r_st  [0:LAST];
    t_stage n_st  [0:LAST];
    logic   r_vld [0:LAST];
    logic   w_adv;

    assign w_adv   = !r_vld[LAST] || i_ready;
    assign o_ready = w_adv;

    // Stage 0: capture item and form light-minus-point deltas
    always_comb begin : c_in
        logic [2:0][19:0] pt;
        pt = {i_point_z, i_point_y, i_point_x};
        n_st[0] = r_st[0];
        n_st[0].nrm = {i_normal_z, i_normal_y, i_normal_x};
        for (int i = 0; i < 3; i++) begin
            n_st[0].dlt[i] = {r_pos[20*i+19], r_pos[20*i +: 20]} - {pt[i][19], pt[i]};
        end
    end

    for (genvar k = 1; k <= LAST; k++) begin : g_st
        localparam bit IS_SQ = (k >= ST_SQ0) && (k < ST_SQ0 + SQ_STEPS);
        localparam int SQ_I  = IS_SQ ? (ST_SQ0 + SQ_STEPS - 1 - k) : 0;
        localparam logic [62:0] SQ_BIT = 63'(1) << (2 * SQ_I);

        always_comb begin : c_stage
            t_stage     p;
            logic [62:0] sq_t;
            logic [43:0] iv_r2;
            logic [31:0] ld_r2;
            logic [30:0] ra_r2;
            logic [31:0] cn_r2;
            logic [20:0] mag;
            logic [14:0] qc;
            logic [15:0] dv;
            logic [34:0] c_sum;
            logic [34:0] n_sum;
            logic [34:0] outer_x;
            logic [34:0] inner_x;
            logic [28:0] t_out;
            p = r_st[k-1];
            n_st[k] = p;

            // Squares of the deltas and of the radius
            if (k == ST_SQR) begin
                for (int i = 0; i < 3; i++) begin
                    n_st[k].sq[i] = 41'($signed({{21{p.dlt[i][20]}}, p.dlt[i]})
                                      * $signed({{21{p.dlt[i][20]}}, p.dlt[i]}));
                end
                n_st[k].rr     = 40'(r_rad) * 40'(r_rad);
                n_st[k].s_zero = (p.dlt == '0);
            end

            // Squared distance, sqrt seed
            if (k == ST_SUM) begin
                n_st[k].s    = 42'(p.sq[0]) + 42'(p.sq[1]) + 42'(p.sq[2]);
                n_st[k].sq_x = 62'({(42'(p.sq[0]) + 42'(p.sq[1]) + 42'(p.sq[2])), 20'b0});
                n_st[k].sq_r = '0;
            end

            // Range test and inverse-square divider seed
            if (k == ST_SQ0) begin
                n_st[k].in_range = (p.s < 42'(p.rr));
                n_st[k].iv_d     = 43'(p.s) + 43'(IV_ONE);
                n_st[k].iv_rem   = IV_ONE;
                n_st[k].iv_q     = '0;
            end

            // One root bit per stage
            if (IS_SQ) begin
                sq_t = p.sq_r + SQ_BIT;
                if ({1'b0, p.sq_x} >= sq_t) begin
                    n_st[k].sq_x = p.sq_x - sq_t[61:0];
                    n_st[k].sq_r = (p.sq_r >> 1) + SQ_BIT;
                end else begin
                    n_st[k].sq_r = p.sq_r >> 1;
                end
            end

            // Inverse-square quotient, one bit per stage
            if (k >= ST_IV0 && k < ST_IV0 + DV_STEPS) begin
                iv_r2 = {p.iv_rem[42:0], 1'b0};
                if (iv_r2 >= {1'b0, p.iv_d}) begin
                    n_st[k].iv_rem = iv_r2 - {1'b0, p.iv_d};
                    n_st[k].iv_q   = {p.iv_q[14:0], 1'b1};
                end else begin
                    n_st[k].iv_rem = iv_r2;
                    n_st[k].iv_q   = {p.iv_q[14:0], 1'b0};
                end
            end

            // Seed light-vector and range-ratio dividers from the distance
            if (k == ST_DIV) begin
                for (int i = 0; i < 3; i++) begin
                    mag = p.dlt[i][20] ? (21'd0 - p.dlt[i]) : p.dlt[i];
                    n_st[k].ld_rem[i] = {2'b0, mag, 9'b0};
                    n_st[k].ld_big[i] = ({2'b0, mag, 9'b0} >= {1'b0, p.sq_r[30:0]});
                    n_st[k].ld_q[i]   = '0;
                end
                n_st[k].ra_d   = {r_rad, 10'b0};
                n_st[k].ra_rem = {1'b0, r_rad, 10'b0} - p.sq_r[30:0];
                n_st[k].ra_q   = '0;
            end

            // Range ratio and light-vector quotients
            if (k >= ST_DV0 && k < ST_DV0 + DV_STEPS) begin
                ra_r2 = {p.ra_rem[29:0], 1'b0};
                if (ra_r2 >= {1'b0, p.ra_d}) begin
                    n_st[k].ra_rem = ra_r2 - {1'b0, p.ra_d};
                    n_st[k].ra_q   = {p.ra_q[14:0], 1'b1};
                end else begin
                    n_st[k].ra_rem = ra_r2;
                    n_st[k].ra_q   = {p.ra_q[14:0], 1'b0};
                end
                if (k < ST_DV0 + LD_STEPS) begin
                    for (int i = 0; i < 3; i++) begin
                        ld_r2 = {p.ld_rem[i][30:0], 1'b0};
                        if (ld_r2 >= {1'b0, p.sq_r[30:0]}) begin
                            n_st[k].ld_rem[i] = ld_r2 - {1'b0, p.sq_r[30:0]};
                            n_st[k].ld_q[i]   = {p.ld_q[i][13:0], 1'b1};
                        end else begin
                            n_st[k].ld_rem[i] = ld_r2;
                            n_st[k].ld_q[i]   = {p.ld_q[i][13:0], 1'b0};
                        end
                    end
                end
            end

            // Light vector (clamped, signed) and distance falloff
            if (k == ST_LV) begin
                for (int i = 0; i < 3; i++) begin
                    qc = (p.ld_big[i] || (p.ld_q[i] > L_MAX)) ? L_MAX : p.ld_q[i];
                    dv = r_dir[16*i +: 16];
                    if (w_pl) begin
                        n_st[k].lv[i] = p.dlt[i][20] ? (17'd0 - {2'b0, qc}) : {2'b0, qc};
                    end else begin
                        n_st[k].lv[i] = 17'd0 - {dv[15], dv};
                    end
                end
                n_st[k].fall = 16'((32'(p.ra_q) * 32'(p.ra_q)) >> 16);
            end

            // Dot-product terms and distance attenuation
            if (k == ST_PROD) begin
                for (int i = 0; i < 3; i++) begin
                    dv = r_dir[16*i +: 16];
                    n_st[k].cprod[i] = 33'($signed({{16{p.lv[i][16]}}, p.lv[i]})
                                         * $signed({{17{dv[15]}}, dv}));
                    n_st[k].nprod[i] = 33'($signed({{16{p.lv[i][16]}}, p.lv[i]})
                                         * $signed({{17{p.nrm[i][15]}}, p.nrm[i]}));
                end
                if (!w_pl) begin
                    n_st[k].att = ONE_Q16;
                end else if (!p.in_range) begin
                    n_st[k].att = '0;
                end else if (w_invsq) begin
                    n_st[k].att = 17'((32'(p.iv_q) * 32'(p.fall)) >> 16);
                end else begin
                    n_st[k].att = {1'b0, p.ra_q};
                end
            end

            // Cone cosine and clamped N dot L
            if (k == ST_DOT) begin
                c_sum = {{2{p.cprod[0][32]}}, p.cprod[0]} + {{2{p.cprod[1][32]}}, p.cprod[1]}
                      + {{2{p.cprod[2][32]}}, p.cprod[2]};
                n_sum = {{2{p.nprod[0][32]}}, p.nprod[0]} + {{2{p.nprod[1][32]}}, p.nprod[1]}
                      + {{2{p.nprod[2][32]}}, p.nprod[2]};
                n_st[k].c   = 35'd0 - c_sum;
                n_st[k].ndl = n_sum[34] ? 32'd0 : n_sum[31:0];
            end

            // Cone tests and cone divider seed
            if (k == ST_CONE) begin
                outer_x = {{5{r_cone[15]}}, r_cone[15:0], 14'b0};
                inner_x = {{5{r_cone[31]}}, r_cone[31:16], 14'b0};
                n_st[k].cone_black = w_spot && ($signed(p.c) < $signed(outer_x));
                n_st[k].cone_use   = w_spot && ($signed(p.c) < $signed(inner_x));
                n_st[k].cn_rem     = 32'(p.c - outer_x);
                n_st[k].cn_d       = 32'(inner_x - outer_x);
                n_st[k].cn_q       = '0;
            end

            // Cone ratio, one bit per stage
            if (k >= ST_CN0 && k < ST_CN0 + DV_STEPS) begin
                cn_r2 = {p.cn_rem[30:0], 1'b0};
                if (cn_r2 >= p.cn_d) begin
                    n_st[k].cn_rem = cn_r2 - p.cn_d;
                    n_st[k].cn_q   = {p.cn_q[14:0], 1'b1};
                end else begin
                    n_st[k].cn_rem = cn_r2;
                    n_st[k].cn_q   = {p.cn_q[14:0], 1'b0};
                end
            end

            if (k == ST_CSQ) begin
                n_st[k].cone_sq = 16'((32'(p.cn_q) * 32'(p.cn_q)) >> 16);
            end

            // Final attenuation and color times intensity
            if (k == ST_ATT) begin
                if (p.cone_use) begin
                    n_st[k].att = 17'((33'(p.att) * 33'(p.cone_sq)) >> 16);
                end
                for (int i = 0; i < 3; i++) begin
                    n_st[k].ci[i] = 32'(r_color[16*i +: 16]) * 32'(r_int);
                end
            end

            if (k == ST_MB) begin
                for (int i = 0; i < 3; i++) begin
                    n_st[k].b[i] = 32'((49'(p.ci[i]) * 49'(p.att)) >> 16);
                end
            end

            if (k == ST_MV) begin
                for (int i = 0; i < 3; i++) begin
                    n_st[k].v[i] = {32'b0, p.b[i]} * {32'b0, p.ndl};
                end
            end

            // Black cases and saturation into the output register
            if (k == LAST) begin
                for (int i = 0; i < 3; i++) begin
                    t_out = p.v[i][63:35];
                    if (!r_act || (w_pl && p.s_zero) || p.cone_black) begin
                        n_st[k].rgb[i] = '0;
                    end else if (t_out > OUT_MAX) begin
                        n_st[k].rgb[i] = OUT_MAX[23:0];
                    end else begin
                        n_st[k].rgb[i] = t_out[23:0];
                    end
                end
            end
        end
    end

    // Payload moves with the global advance
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int k = 0; k <= LAST; k++) begin
                r_st[k] <= n_st[k];
            end
        end
    end

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= LAST; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (w_adv) begin
            r_vld[0] <= i_valid;
            for (int k = 1; k <= LAST; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    assign o_valid     = r_vld[LAST];
    assign o_red_out   = r_st[LAST].rgb[0];
    assign o_green_out = r_st[LAST].rgb[1];
    assign o_blue_out  = r_st[LAST].rgb[2];

endmodule

>>> src/lcs_checker.sv
// ----------------------------------------------------------------------------
// lcs_checker
// Port-level checks of the light contribution shader, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lcs_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [23:0] o_red_out,
    input logic [23:0] o_green_out,
    input logic [23:0] o_blue_out
);

    // a stalled result item stays offered
    `LCS_ASSERT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready |=> o_valid, "result dropped")

    // a stalled result item keeps its payload
    `LCS_ASSERT(a_out_stable, i_clk, i_rst_n, o_valid && !i_ready |=> $stable(o_red_out) && $stable(o_green_out) && $stable(o_blue_out), "result changed while stalled")

    // a stalled output freezes the whole pipe, so no new item is taken
    `LCS_ASSERT(a_stall_blocks_in, i_clk, i_rst_n, o_valid && !i_ready |-> !o_ready, "input taken while output stalled")

    // reset empties the pipe
    `LCS_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !o_valid, "result valid after reset")

endmodule

bind light_contribution_shader_unit lcs_checker u_lcs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_ready     (o_ready),
    .o_valid     (o_valid),
    .i_ready     (i_ready),
    .o_red_out   (o_red_out),
    .o_green_out (o_green_out),
    .o_blue_out  (o_blue_out)
);
